### hdl/irhd_pkg.sv
// Package for the IR hand dispenser controller: event codes, register
// indexes and fixed timing constants. No dependencies.
package irhd_pkg;

  typedef enum logic [2:0] {
    CMD_WAKE  = 3'd0,
    CMD_TICK1 = 3'd1,
    CMD_TICK10 = 3'd2,
    CMD_FALL  = 3'd3,
    CMD_RISE  = 3'd4,
    CMD_BRAKE = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    REG_LOW_VOLT  = 3'd0,
    REG_DUAL_DOSE = 3'd1,
    REG_RUN_TMO   = 3'd2,
    REG_BRAKE_MIN = 3'd3,
    REG_HAND_LIM  = 3'd4
  } reg_idx_t;

  localparam logic [9:0] LOW_VOLT_RST  = 10'd530;
  localparam logic [9:0] RUN_TMO_RST   = 10'd400;
  localparam logic [9:0] BRAKE_MIN_RST = 10'd40;
  localparam logic [7:0] HAND_LIM_RST  = 8'd5;
  localparam logic [6:0] KICK_PERIOD   = 7'd100;
  localparam logic [7:0] EMIT_LOOP     = 8'd203;
  localparam logic [7:0] EMIT_END      = 8'd13;
  localparam logic [6:0] QUIET_STOP    = 7'd60;
  localparam logic [6:0] QUIET_DONE    = 7'd80;
  localparam logic [4:0] BLINK_PERIOD  = 5'd25;
  localparam logic [9:0] STOP_TICKS    = 10'd30;
  localparam logic [9:0] HOLD_TICKS    = 10'd100;

endpackage

### hdl/ir_hand_dispenser_controller_unit.sv
// IR hand dispenser controller, top level: event decode, state update and
// registered result. Depends on irhd_pkg.
//
// One event is accepted per clock while the skid slot is empty, and its result (the
// outputs after the event) is registered in the output register, or in the skid slot
// while the output is held; a single skid stage lets a new event enter while a result
// still waits. The result comes from the combinational state update of the state registers.
module ir_hand_dispenser_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [2:0] cmd, [12:3] battery_level
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // asleep, carrier_enable, receiver_on, motor_on,
                                  // brake_drive, green_lamp, yellow_lamp,
                                  // watchdog_kick, low_voltage, hand_held
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  // configuration
  logic [9:0] lvt_r, tmo_r, bmin_r;
  logic       dual_r;
  logic [7:0] hlim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvt_r  <= irhd_pkg::LOW_VOLT_RST;
      dual_r <= 1'b0;
      tmo_r  <= irhd_pkg::RUN_TMO_RST;
      bmin_r <= irhd_pkg::BRAKE_MIN_RST;
      hlim_r <= irhd_pkg::HAND_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        irhd_pkg::REG_LOW_VOLT:  lvt_r  <= cfg_data;
        irhd_pkg::REG_DUAL_DOSE: dual_r <= cfg_data[0];
        irhd_pkg::REG_RUN_TMO:   tmo_r  <= cfg_data;
        irhd_pkg::REG_BRAKE_MIN: bmin_r <= cfg_data;
        irhd_pkg::REG_HAND_LIM:  hlim_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // state
  logic sreq_r, emit_r, car_r, rcv_r, edge_r, slow_r, run_r, brk_r, hand_r;
  logic bl_r, stop_r, pt_r, gon_r, yon_r;
  logic [7:0] ems_r, pms_r, hp_r, hpk_r;
  logic [9:0] st_r;
  logic [6:0] qt_r, yb_r, kc_r;
  logic [4:0] gb_r, hb_r;
  logic [1:0] dc_r, dw_r;

  logic sreq_nxt, emit_nxt, car_nxt, rcv_nxt, edge_nxt, slow_nxt, run_nxt, brk_nxt;
  logic hand_nxt, bl_nxt, stop_nxt, pt_nxt, gon_nxt, yon_nxt, kick;
  logic [7:0] ems_nxt, pms_nxt, hp_nxt, hpk_nxt;
  logic [9:0] st_nxt;
  logic [6:0] qt_nxt, yb_nxt, kc_nxt;
  logic [4:0] gb_nxt, hb_nxt;
  logic [1:0] dc_nxt, dw_nxt;

  // output stage with one skid slot
  logic        o_vld_r, s_vld_r;
  logic [9:0]  o_dat_r, s_dat_r;
  logic        xfer;
  logic [9:0]  res;

  assign in_tready = !s_vld_r;
  assign xfer      = in_tvalid && in_tready;

  logic [2:0] cmd;
  logic [9:0] batt;
  logic       slept, wake;
  assign cmd  = in_tdata[2:0];
  assign batt = in_tdata[12:3];
  assign slept = sreq_r && !run_r && !brk_r && !hand_r && !bl_r;

  // event handling
  always_comb begin
    sreq_nxt = sreq_r; emit_nxt = emit_r; car_nxt = car_r; rcv_nxt = rcv_r;
    edge_nxt = edge_r; slow_nxt = slow_r; run_nxt = run_r; brk_nxt = brk_r;
    hand_nxt = hand_r; bl_nxt = bl_r; stop_nxt = stop_r; pt_nxt = pt_r;
    gon_nxt = gon_r; yon_nxt = yon_r; ems_nxt = ems_r; pms_nxt = pms_r;
    hp_nxt = hp_r; hpk_nxt = hpk_r; st_nxt = st_r; qt_nxt = qt_r;
    yb_nxt = yb_r; kc_nxt = kc_r; gb_nxt = gb_r; hb_nxt = hb_r;
    dc_nxt = dc_r; dw_nxt = dw_r;
    kick = 1'b0;
    wake = 1'b0;
    case (cmd)
      irhd_pkg::CMD_WAKE: wake = slept;
      irhd_pkg::CMD_TICK1: begin
        if (!slept) begin
          kc_nxt = kc_r + 7'd1;
          if (kc_nxt == irhd_pkg::KICK_PERIOD) begin
            kc_nxt = '0;
            kick = 1'b1;
          end
          if (emit_r) begin
            ems_nxt = ems_r + 8'd1;
            if (ems_nxt == 8'd4) rcv_nxt = 1'b1;
            if (ems_nxt == 8'd5) edge_nxt = 1'b1;
            if (ems_nxt == 8'd6) car_nxt = 1'b1;
            if (ems_nxt == 8'd11) car_nxt = 1'b0;
            if (ems_nxt == 8'd12) edge_nxt = 1'b0;
            if (ems_nxt == irhd_pkg::EMIT_END && !run_r && !brk_r) begin
              ems_nxt = '0;
              gb_nxt = gb_r + 5'd1;
              if (dual_r && dc_r == 2'd1) begin
                dw_nxt = dw_r + 2'd1;
                if (dw_nxt == 2'd2) begin
                  dw_nxt = '0;
                  dc_nxt = '0;
                end
              end
              rcv_nxt = 1'b0;
              sreq_nxt = 1'b1;
              slow_nxt = 1'b0;
            end
            if (ems_nxt == irhd_pkg::EMIT_LOOP && !run_r && brk_r) ems_nxt = 8'd3;
          end
          if (!run_r && !brk_r && !hand_r && !bl_r) begin
            if (gb_nxt == 5'd3) gon_nxt = 1'b0;
            if (gb_nxt == irhd_pkg::BLINK_PERIOD) begin
              gb_nxt = '0;
              gon_nxt = 1'b1;
            end
          end
          if (bl_r && run_r && !brk_r) begin
            yb_nxt = yb_r + 7'd1;
            if (yb_nxt == irhd_pkg::KICK_PERIOD) begin
              yb_nxt = '0;
              yon_nxt = !yon_r;
            end
          end
          if (pt_r && pms_r != 8'hFF) pms_nxt = pms_r + 8'd1;
        end
      end
      irhd_pkg::CMD_TICK10: begin
        if (!slept && slow_r) begin
          if (run_r && !brk_r) begin
            st_nxt = st_r + 10'd1;
            if (st_nxt >= tmo_r) begin
              run_nxt = 1'b0; brk_nxt = 1'b1;
              if (bl_r) begin
                yon_nxt = 1'b0; bl_nxt = 1'b0;
              end
              stop_nxt = 1'b1; st_nxt = '0; slow_nxt = 1'b1;
              emit_nxt = 1'b1; car_nxt = 1'b0; ems_nxt = '0; rcv_nxt = 1'b1;
            end
          end
          if (brk_nxt && !run_nxt) begin
            if (!hand_r) begin
              st_nxt = st_nxt + 10'd1;
              if (st_nxt == irhd_pkg::STOP_TICKS) begin
                stop_nxt = 1'b0;
                if (dual_r) begin
                  if (dc_r == 2'd1) begin
                    brk_nxt = 1'b0; gb_nxt = '0; gon_nxt = 1'b1; slow_nxt = 1'b0;
                    sreq_nxt = 1'b1; st_nxt = '0; dw_nxt = '0;
                  end
                  if (dc_r == 2'd2) dc_nxt = '0;
                end
              end
              if (st_nxt == irhd_pkg::HOLD_TICKS) begin
                st_nxt = '0;
                if (hp_r < hlim_r) begin
                  hp_nxt = '0;
                  brk_nxt = 1'b0; gb_nxt = '0; gon_nxt = 1'b1; slow_nxt = 1'b0;
                  sreq_nxt = 1'b1;
                end else begin
                  hand_nxt = 1'b1; yon_nxt = 1'b1; hb_nxt = '0;
                end
              end
            end else begin
              hb_nxt = hb_r + 5'd1;
              if (hb_nxt == irhd_pkg::BLINK_PERIOD) begin
                hb_nxt = '0;
                yon_nxt = !yon_r;
              end
              if (hpk_r < hp_r) begin
                hpk_nxt = hp_r;
                qt_nxt = '0;
              end else begin
                qt_nxt = qt_r + 7'd1;
                if (qt_nxt >= irhd_pkg::QUIET_STOP) begin
                  emit_nxt = 1'b0; car_nxt = 1'b0;
                end
                if (qt_nxt >= irhd_pkg::QUIET_DONE) begin
                  qt_nxt = '0; hpk_nxt = '0; hp_nxt = '0; hand_nxt = 1'b0;
                  yon_nxt = 1'b0;
                  brk_nxt = 1'b0; gb_nxt = '0; gon_nxt = 1'b1; slow_nxt = 1'b0;
                  sreq_nxt = 1'b1;
                end
              end
            end
          end
        end
      end
      irhd_pkg::CMD_FALL: begin
        if (edge_r) begin
          sreq_nxt = 1'b0; pt_nxt = 1'b1; pms_nxt = '0;
          wake = slept;
        end
      end
      irhd_pkg::CMD_RISE: begin
        if (edge_r) begin
          sreq_nxt = 1'b0; pt_nxt = 1'b0;
          if (!brk_r && !run_r && pms_r == 8'd5) begin
            gon_nxt = 1'b0; emit_nxt = 1'b0; car_nxt = 1'b0; rcv_nxt = 1'b0;
            if (dual_r) dc_nxt = dc_r + 2'd1;
            if (batt < lvt_r) begin
              bl_nxt = 1'b1; yon_nxt = 1'b1; yb_nxt = '0;
            end
            run_nxt = 1'b1; stop_nxt = 1'b0; slow_nxt = 1'b1;
          end
          if (brk_r && !run_r && pms_r > 8'd4 && pms_r <= 8'd8 && hp_r != 8'hFF)
            hp_nxt = hp_r + 8'd1;
          pms_nxt = '0;
          wake = slept;
        end
      end
      irhd_pkg::CMD_BRAKE: begin
        if (run_r && !brk_r && st_r > bmin_r) begin
          run_nxt = 1'b0; brk_nxt = 1'b1;
          if (bl_r) begin
            yon_nxt = 1'b0; bl_nxt = 1'b0;
          end
          stop_nxt = 1'b1; st_nxt = '0; slow_nxt = 1'b1;
          if (!dual_r || dc_r == 2'd2) begin
            emit_nxt = 1'b1; car_nxt = 1'b0; ems_nxt = '0; rcv_nxt = 1'b1;
          end
        end
        wake = slept;
      end
      default: ;
    endcase
    if (wake) begin
      sreq_nxt = 1'b0; emit_nxt = 1'b1; car_nxt = 1'b0; ems_nxt = '0;
    end
  end

  assign res = {hand_nxt, bl_nxt, kick, yon_nxt, gon_nxt, stop_nxt, run_nxt, rcv_nxt,
                car_nxt,
                sreq_nxt && !run_nxt && !brk_nxt && !hand_nxt && !bl_nxt};

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sreq_r <= 1'b1; emit_r <= 1'b0; car_r <= 1'b0; rcv_r <= 1'b0; edge_r <= 1'b0;
      slow_r <= 1'b0; run_r <= 1'b0; brk_r <= 1'b0; hand_r <= 1'b0; bl_r <= 1'b0;
      stop_r <= 1'b0; pt_r <= 1'b0; gon_r <= 1'b1; yon_r <= 1'b0;
      ems_r <= '0; pms_r <= '0; hp_r <= '0; hpk_r <= '0; st_r <= '0; qt_r <= '0;
      yb_r <= '0; kc_r <= '0; gb_r <= '0; hb_r <= '0; dc_r <= '0; dw_r <= '0;
    end else if (xfer) begin
      sreq_r <= sreq_nxt; emit_r <= emit_nxt; car_r <= car_nxt; rcv_r <= rcv_nxt;
      edge_r <= edge_nxt; slow_r <= slow_nxt; run_r <= run_nxt; brk_r <= brk_nxt;
      hand_r <= hand_nxt; bl_r <= bl_nxt; stop_r <= stop_nxt; pt_r <= pt_nxt;
      gon_r <= gon_nxt; yon_r <= yon_nxt; ems_r <= ems_nxt; pms_r <= pms_nxt;
      hp_r <= hp_nxt; hpk_r <= hpk_nxt; st_r <= st_nxt; qt_r <= qt_nxt;
      yb_r <= yb_nxt; kc_r <= kc_nxt; gb_r <= gb_nxt; hb_r <= hb_nxt;
      dc_r <= dc_nxt; dw_r <= dw_nxt;
    end
  end

  // result register plus skid slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
    end else begin
      if (!o_vld_r || out_tready) begin
        if (s_vld_r) begin
          o_vld_r <= 1'b1;
          o_dat_r <= s_dat_r;
          s_vld_r <= 1'b0;
        end else begin
          o_vld_r <= xfer;
          o_dat_r <= res;
        end
      end else if (xfer) begin
        s_vld_r <= 1'b1;
        s_dat_r <= res;
      end
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = {6'd0, o_dat_r};

endmodule

### tb/tb.sv
// Self-checking bench for ir_hand_dispenser_controller_unit: event streams,
// per-event status prediction and compare. Depends on irhd_pkg and the RTL.
module tb;

  typedef struct packed {
    logic [2:0] cmd;
    logic [9:0] battery;
  } event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;

  ir_hand_dispenser_controller_unit DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  event_t      pending_q[$];
  logic [9:0]  status_q[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          in_burst = 0, out_burst = 0;

  // Shadow registers and state of the controller
  logic [9:0] r_lowv, r_runtmo, r_bmin;
  logic       r_dual;
  logic [7:0] r_hlim;
  logic       sleep_req, emit_act, carr_act, recv_act, edge_en, slow_on, running, braking;
  logic       hand_pres, bat_low, stop_drv, pulse_tim, green_on, yellow_on;
  logic [7:0] emit_ms, pulse_ms, hand_pulses, hand_peak;
  logic [9:0] slow_ticks;
  logic [6:0] quiet_ticks, yellow_blink, kick_count;
  logic [4:0] green_blink, hand_blink;
  logic [1:0] dose_count, dose_wait;

  function automatic logic dispenser_asleep();
    return sleep_req && !running && !braking && !hand_pres && !bat_low;
  endfunction

  task automatic restart_emit();
    emit_act = 1; carr_act = 0; emit_ms = 0;
  endtask

  task automatic finish_use();
    braking = 0; green_blink = 0; green_on = 1; slow_on = 0; sleep_req = 1;
  endtask

  task automatic enter_brake();
    running = 0; braking = 1;
    if (bat_low) begin
      yellow_on = 0; bat_low = 0;
    end
    stop_drv = 1; slow_ticks = 0; slow_on = 1;
  endtask

  task automatic fast_tick(output logic kick);
    kick = 0;
    kick_count = kick_count + 7'd1;
    if (kick_count == irhd_pkg::KICK_PERIOD) begin
      kick_count = 0; kick = 1;
    end
    if (emit_act) begin
      emit_ms = emit_ms + 8'd1;
      if (emit_ms == 4) recv_act = 1;
      if (emit_ms == 5) edge_en = 1;
      if (emit_ms == 6) carr_act = 1;
      if (emit_ms == 11) carr_act = 0;
      if (emit_ms == 12) edge_en = 0;
      if (emit_ms == irhd_pkg::EMIT_END && !running && !braking) begin
        emit_ms = 0;
        green_blink = green_blink + 5'd1;
        if (r_dual && dose_count == 1) begin
          dose_wait = dose_wait + 2'd1;
          if (dose_wait == 2) begin
            dose_wait = 0; dose_count = 0;
          end
        end
        recv_act = 0; sleep_req = 1; slow_on = 0;
      end
      if (emit_ms == irhd_pkg::EMIT_LOOP && !running && braking) emit_ms = 3;
    end
    if (!running && !braking && !hand_pres && !bat_low) begin
      if (green_blink == 3) green_on = 0;
      if (green_blink == irhd_pkg::BLINK_PERIOD) begin
        green_blink = 0; green_on = 1;
      end
    end
    if (bat_low && running && !braking) begin
      yellow_blink = yellow_blink + 7'd1;
      if (yellow_blink == 100) begin
        yellow_blink = 0; yellow_on = !yellow_on;
      end
    end
    if (pulse_tim && pulse_ms != 8'd255) pulse_ms = pulse_ms + 8'd1;
  endtask

  task automatic slow_tick();
    if (running && !braking) begin
      slow_ticks = slow_ticks + 10'd1;
      if (slow_ticks >= r_runtmo) begin
        enter_brake(); restart_emit(); recv_act = 1;
      end
    end
    if (braking && !running) begin
      if (!hand_pres) begin
        slow_ticks = slow_ticks + 10'd1;
        if (slow_ticks == irhd_pkg::STOP_TICKS) begin
          stop_drv = 0;
          if (r_dual) begin
            if (dose_count == 1) begin
              finish_use(); slow_ticks = 0; dose_wait = 0;
            end
            if (dose_count == 2) dose_count = 0;
          end
        end
        if (slow_ticks == irhd_pkg::HOLD_TICKS) begin
          slow_ticks = 0;
          if (hand_pulses < r_hlim) begin
            hand_pulses = 0; finish_use();
          end else begin
            hand_pres = 1; yellow_on = 1; hand_blink = 0;
          end
        end
      end else begin
        hand_blink = hand_blink + 5'd1;
        if (hand_blink == irhd_pkg::BLINK_PERIOD) begin
          hand_blink = 0; yellow_on = !yellow_on;
        end
        if (hand_peak < hand_pulses) begin
          hand_peak = hand_pulses; quiet_ticks = 0;
        end else begin
          quiet_ticks = quiet_ticks + 7'd1;
          if (quiet_ticks >= irhd_pkg::QUIET_STOP) begin
            emit_act = 0; carr_act = 0;
          end
          if (quiet_ticks >= irhd_pkg::QUIET_DONE) begin
            quiet_ticks = 0; hand_peak = 0; hand_pulses = 0; hand_pres = 0;
            yellow_on = 0; finish_use();
          end
        end
      end
    end
  endtask

  task automatic echo_edge(input logic rise, input logic [9:0] bat);
    sleep_req = 0;
    if (!rise) begin
      pulse_tim = 1; pulse_ms = 0;
    end else begin
      pulse_tim = 0;
      if (!braking && !running && pulse_ms == 5) begin
        green_on = 0; emit_act = 0; carr_act = 0; recv_act = 0;
        if (r_dual) dose_count = dose_count + 2'd1;
        if (bat < r_lowv) begin
          bat_low = 1; yellow_on = 1; yellow_blink = 0;
        end
        running = 1; braking = 0; stop_drv = 0; slow_on = 1;
      end
      if (braking && !running && pulse_ms > 4 && pulse_ms <= 8 && hand_pulses != 8'd255)
        hand_pulses = hand_pulses + 8'd1;
      pulse_ms = 0;
    end
  endtask

  // Advance the shadow state by one event and return the expected status word
  task automatic predict_status(input event_t ev, output logic [9:0] st);
    logic slept, wake, kick;
    slept = dispenser_asleep();
    wake = 0;
    kick = 0;
    case (ev.cmd)
      irhd_pkg::CMD_WAKE: wake = slept;
      irhd_pkg::CMD_TICK1: if (!slept) fast_tick(kick);
      irhd_pkg::CMD_TICK10: if (!slept && slow_on) slow_tick();
      irhd_pkg::CMD_FALL, irhd_pkg::CMD_RISE: if (edge_en) begin
        echo_edge(ev.cmd == irhd_pkg::CMD_RISE, ev.battery);
        wake = slept;
      end
      irhd_pkg::CMD_BRAKE: begin
        if (running && !braking && slow_ticks > r_bmin) begin
          enter_brake();
          if (!r_dual || dose_count == 2) begin
            restart_emit(); recv_act = 1;
          end
        end
        wake = slept;
      end
      default: ;
    endcase
    if (wake) begin
      sleep_req = 0; restart_emit();
    end
    st = {hand_pres, bat_low, kick, yellow_on, green_on, stop_drv, running, recv_act,
          carr_act, dispenser_asleep()};
  endtask

  // Input driver
  always @(posedge clk) begin
    event_t ev;
    int gap;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap = 0;
    end else if (in_tvalid && !in_tready) begin
      // hold until the transfer happens
    end else if (gap != 0) begin
      in_tvalid <= 1'b0;
      gap = gap - 1;
    end else if (pending_q.size() != 0) begin
      ev = pending_q.pop_front();
      in_tdata <= {3'b000, ev.battery, ev.cmd};
      in_tvalid <= 1'b1;
      if ($urandom_range(0, 40) == 0) in_burst = !in_burst;
      gap = in_burst ? 0 : $urandom_range(0, 19);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Predict on every accepted event
  always @(posedge clk) begin
    logic [9:0] st;
    if (rst_n && in_tvalid && in_tready) begin
      predict_status('{cmd: in_tdata[2:0], battery: in_tdata[12:3]}, st);
      status_q.push_back(st);
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin
    logic [9:0] exp_st;
    int stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (status_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_tdata);
          errors++;
        end else begin
          exp_st = status_q.pop_front();
          if (out_tdata !== {6'b0, exp_st}) begin
            $display("%0t: status mismatch expected %h actual %h", $time,
                     {6'b0, exp_st}, out_tdata);
            errors++;
          end
        end
        if ($urandom_range(0, 40) == 0) out_burst = !out_burst;
        stall = out_burst ? 0 : $urandom_range(0, 19);
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        stall = stall - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on transfer progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_ev(input logic [2:0] c, input logic [9:0] b = 10'($urandom));
    pending_q.push_back('{cmd: c, battery: b});
  endtask

  task automatic push_ticks(input logic [2:0] c, input int n);
    for (int i = 0; i < n; i++) push_ev(c);
  endtask

  // One hand use: wake, burst, echo, run, brake, hand echo, brake ticks
  task automatic push_use(input int plen, input logic [9:0] bat);
    int n_hand;
    push_ev(irhd_pkg::CMD_WAKE);
    push_ticks(irhd_pkg::CMD_TICK1, 5);
    push_ev(irhd_pkg::CMD_FALL);
    push_ticks(irhd_pkg::CMD_TICK1, plen);
    push_ev(irhd_pkg::CMD_RISE, bat);
    for (int i = $urandom_range(0, 60); i > 0; i--)
      push_ev($urandom_range(0, 3) == 0 ? irhd_pkg::CMD_TICK1 : irhd_pkg::CMD_TICK10);
    push_ev(irhd_pkg::CMD_BRAKE);
    n_hand = $urandom_range(0, 2);
    for (int h = 0; h < n_hand; h++) begin
      push_ticks(irhd_pkg::CMD_TICK1, 5);
      push_ev(irhd_pkg::CMD_FALL);
      push_ticks(irhd_pkg::CMD_TICK1, $urandom_range(5, 8));
      push_ev(irhd_pkg::CMD_RISE);
      push_ticks(irhd_pkg::CMD_TICK1, 1);
    end
    push_ticks(irhd_pkg::CMD_TICK10, $urandom_range(20, 110));
    if ($urandom_range(0, 2) == 0) push_ticks(irhd_pkg::CMD_TICK10, 90);
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || status_q.size() != 0 || in_tvalid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the enable is raised and dropped on separate edges
  task automatic write_reg(input irhd_pkg::reg_idx_t idx, input logic [9:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      irhd_pkg::REG_LOW_VOLT: r_lowv = val;
      irhd_pkg::REG_DUAL_DOSE: r_dual = val[0];
      irhd_pkg::REG_RUN_TMO: r_runtmo = val;
      irhd_pkg::REG_BRAKE_MIN: r_bmin = val;
      irhd_pkg::REG_HAND_LIM: r_hlim = val[7:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
  endtask

  initial begin
    int budget;
    {sleep_req, green_on} = 2'b11;
    {emit_act, carr_act, recv_act, edge_en, slow_on, running, braking} = '0;
    {hand_pres, bat_low, stop_drv, pulse_tim, yellow_on} = '0;
    {emit_ms, pulse_ms, hand_pulses, hand_peak, slow_ticks} = '0;
    {quiet_ticks, yellow_blink, kick_count, green_blink, hand_blink} = '0;
    {dose_count, dose_wait} = '0;
    r_lowv = irhd_pkg::LOW_VOLT_RST; r_dual = 0; r_runtmo = irhd_pkg::RUN_TMO_RST;
    r_bmin = irhd_pkg::BRAKE_MIN_RST; r_hlim = irhd_pkg::HAND_LIM_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ignored events, unused codes, extreme batteries
    push_ev(irhd_pkg::CMD_TICK1); push_ev(irhd_pkg::CMD_TICK10);
    push_ev(irhd_pkg::CMD_FALL);
    push_ev(3'd6, 10'h3FF); push_ev(3'd7, 10'h000);
    push_use(5, 10'd0);
    push_ev(irhd_pkg::CMD_WAKE); push_ev(irhd_pkg::CMD_BRAKE);
    push_use(5, 10'h3FF);
    push_use(4, 10'd600);
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(irhd_pkg::REG_LOW_VOLT, 10'h3FF);
          write_reg(irhd_pkg::REG_DUAL_DOSE, 10'd1);
          write_reg(irhd_pkg::REG_RUN_TMO, 10'd1);
          write_reg(irhd_pkg::REG_BRAKE_MIN, 10'd0);
          write_reg(irhd_pkg::REG_HAND_LIM, 10'd1);
        end
        1: begin
          write_reg(irhd_pkg::REG_LOW_VOLT, 10'd0);
          write_reg(irhd_pkg::REG_DUAL_DOSE, 10'd0);
          write_reg(irhd_pkg::REG_RUN_TMO, 10'h3FF);
          write_reg(irhd_pkg::REG_BRAKE_MIN, 10'h3FF);
          write_reg(irhd_pkg::REG_HAND_LIM, 10'd255);
        end
        2: begin
          write_reg(irhd_pkg::REG_LOW_VOLT, 10'd512);
          write_reg(irhd_pkg::REG_DUAL_DOSE, 10'd1);
          write_reg(irhd_pkg::REG_RUN_TMO, 10'd40);
          write_reg(irhd_pkg::REG_BRAKE_MIN, 10'd10);
          write_reg(irhd_pkg::REG_HAND_LIM, 10'd2);
        end
        default: begin
          write_reg(irhd_pkg::REG_LOW_VOLT, 10'd530);
          write_reg(irhd_pkg::REG_DUAL_DOSE, 10'd0);
          write_reg(irhd_pkg::REG_RUN_TMO, 10'd30);
          write_reg(irhd_pkg::REG_BRAKE_MIN, 10'd5);
          write_reg(irhd_pkg::REG_HAND_LIM, 10'd1);
        end
      endcase
      budget = pending_q.size() + 60;
      while (pending_q.size() < budget) begin
        if ($urandom_range(0, 4) != 0)
          push_use($urandom_range(0, 5) == 0 ? $urandom_range(3, 7) : 5, 10'($urandom));
        else
          for (int i = 0; i < 8; i++) push_ev(3'($urandom));
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && status_q.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
